// File: hdl/gaze_moving_average_outlier_macros.svh
// Assertion macros shared by the gaze moving-average filter modules.
`ifndef GAZE_MOVING_AVERAGE_OUTLIER_MACROS_SVH
`define GAZE_MOVING_AVERAGE_OUTLIER_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define GMA_ASSERT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define GMA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/gma_pkg.sv
// Shared constants and command/status types of the gaze moving-average filter.
`default_nettype none

package gma_pkg;

  // Window depth used when the top level is not overridden.
  localparam int WINDOW_DEF = 8;

  // Field widths.
  localparam int COORD_W = 16;
  localparam int GAUSS_W = 4;
  localparam int KSQ_W   = 2 * GAUSS_W;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = GAUSS_W;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTLIER_ENABLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAUSS_FACTOR   = 1'b1;
  localparam logic [GAUSS_W-1:0]   GAUSS_RESET        = 4'd3;

  // Operations the sequencer hands to each axis lane.
  typedef enum logic [1:0] {
    OP_TEST,
    OP_PUSH,
    OP_AVG
  } gma_op_t;

  typedef struct packed {
    logic    start;
    gma_op_t op;
    logic    keep;
  } gma_cmd_t;

  typedef struct packed {
    logic done;
    logic outside;
  } gma_sts_t;

endpackage

`default_nettype wire

// File: hdl/gma_if.sv
// Valid/ready channel interfaces for gaze points and window averages.
`default_nettype none

interface gma_gaze_if;
  logic                         valid;
  logic                         ready;
  logic [gma_pkg::COORD_W-1:0]  gaze_x;
  logic [gma_pkg::COORD_W-1:0]  gaze_y;

  modport source (output valid, output gaze_x, output gaze_y, input ready);
  modport sink (input valid, input gaze_x, input gaze_y, output ready);
endinterface

interface gma_avg_if;
  logic                         valid;
  logic                         ready;
  logic [gma_pkg::COORD_W-1:0]  avg_x;
  logic [gma_pkg::COORD_W-1:0]  avg_y;

  modport source (output valid, output avg_x, output avg_y, input ready);
  modport sink (input valid, input avg_x, input avg_y, output ready);
endinterface

`default_nettype wire

// File: hdl/gma_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module gma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: hdl/gma_axis.sv
// One axis lane: ring store, running sums, bit-serial multiplier and divider.
`default_nettype none
`include "gaze_moving_average_outlier_macros.svh"

module gma_axis #(
  parameter int WINDOW = gma_pkg::WINDOW_DEF,
  localparam int AW = $clog2(WINDOW)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire gma_pkg::gma_cmd_t             cmd,
  input  wire logic [AW-1:0]                 slot,
  input  wire logic                          filled,
  input  wire logic [gma_pkg::GAUSS_W-1:0]   gauss,
  input  wire logic [gma_pkg::COORD_W-1:0]   v,
  output gma_pkg::gma_sts_t                  sts,
  output logic      [gma_pkg::COORD_W-1:0]   avg
);

  localparam int CW_  = gma_pkg::COORD_W;
  localparam int LW   = $clog2(WINDOW);
  localparam int SW   = CW_ + LW;
  localparam int QW   = 2 * CW_ + LW;
  localparam int PW   = 2 * SW + gma_pkg::KSQ_W;
  localparam int RW   = LW + 1;
  localparam int NW   = $clog2(CW_);
  localparam logic [SW-1:0] W_SW     = SW'(WINDOW);
  localparam logic [RW-1:0] W_RW     = RW'(WINDOW);
  localparam logic [NW-1:0] CNT_LAST = NW'(CW_ - 1);

  typedef enum logic [3:0] {
    A_IDLE,
    A_MEAN,
    A_WV,
    A_SS,
    A_WQ,
    A_DD,
    A_KV,
    A_RD,
    A_NN,
    A_OO,
    A_AVG
  } axis_state_t;

  axis_state_t state_r, state_nxt;
  logic [SW-1:0]     sum_r, sum_nxt;
  logic [QW-1:0]     sumsq_r, sumsq_nxt;
  logic [CW_-1:0]    mean_r, mean_nxt;
  logic [CW_-1:0]    avg_r, avg_nxt;
  logic [SW-1:0]     d_r, d_nxt;
  logic [2*SW-1:0]   ss_r, ss_nxt;
  logic [2*SW-1:0]   var_r, var_nxt;
  logic [2*SW-1:0]   dd_r, dd_nxt;
  logic [CW_-1:0]    n_r, n_nxt;
  logic [CW_-1:0]    o_r, o_nxt;
  logic              outside_r, outside_nxt;
  logic              done_r, done_nxt;
  logic [PW-1:0]     ma_r, ma_nxt;
  logic [SW-1:0]     mb_r, mb_nxt;
  logic [PW-1:0]     macc_r, macc_nxt;
  logic [CW_-1:0]    dv_r, dv_nxt;
  logic [RW-1:0]     rem_r, rem_nxt;
  logic [NW-1:0]     cnt_r, cnt_nxt;

  logic [gma_pkg::KSQ_W-1:0] ksq;
  logic              mul_fin;
  logic [PW-1:0]     macc_step;
  logic [RW-1:0]     div_t;
  logic              div_ge;
  logic [RW-1:0]     div_rem;
  logic [CW_-1:0]    div_quot;
  logic [SW-1:0]     wv;
  logic [2*SW-1:0]   wq;
  logic              ram_we;
  logic [CW_-1:0]    ram_rdata;

  // Ring of stored values for this axis.
  gma_ram #(
    .WIDTH (CW_),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (n_r),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  assign ksq = gma_pkg::KSQ_W'(gauss) * gma_pkg::KSQ_W'(gauss);

  // Shift-add multiplier: one multiplier bit per cycle, done when it runs out.
  assign mul_fin   = (mb_r == '0);
  assign macc_step = macc_r + (mb_r[0] ? ma_r : '0);

  // Restoring divider by the window depth: one quotient bit per cycle.
  assign div_t    = {rem_r[RW-2:0], dv_r[CW_-1]};
  assign div_ge   = (div_t >= W_RW);
  assign div_rem  = div_ge ? (div_t - W_RW) : div_t;
  assign div_quot = {dv_r[CW_-2:0], div_ge};

  assign wv = macc_r[SW-1:0];
  assign wq = macc_r[2*SW-1:0];

  // Sequencer of the lane and its datapath.
  always_comb begin
    state_nxt   = state_r;
    sum_nxt     = sum_r;
    sumsq_nxt   = sumsq_r;
    mean_nxt    = mean_r;
    avg_nxt     = avg_r;
    d_nxt       = d_r;
    ss_nxt      = ss_r;
    var_nxt     = var_r;
    dd_nxt      = dd_r;
    n_nxt       = n_r;
    o_nxt       = o_r;
    outside_nxt = outside_r;
    done_nxt    = 1'b0;
    ma_nxt      = ma_r;
    mb_nxt      = mb_r;
    macc_nxt    = macc_r;
    dv_nxt      = dv_r;
    rem_nxt     = rem_r;
    cnt_nxt     = cnt_r;
    ram_we      = 1'b0;

    // The multiplier advances whenever bits of its multiplier are left.
    if (!mul_fin) begin
      macc_nxt = macc_step;
      ma_nxt   = ma_r << 1;
      mb_nxt   = mb_r >> 1;
    end

    unique case (state_r)
      A_IDLE: begin
        if (cmd.start) begin
          unique case (cmd.op)
            gma_pkg::OP_TEST: begin
              rem_nxt   = RW'(sum_r[SW-1:CW_]);
              dv_nxt    = sum_r[CW_-1:0];
              cnt_nxt   = CNT_LAST;
              state_nxt = A_MEAN;
            end
            gma_pkg::OP_PUSH: begin
              n_nxt     = cmd.keep ? v : mean_r;
              state_nxt = A_RD;
            end
            gma_pkg::OP_AVG: begin
              rem_nxt   = RW'(sum_r[SW-1:CW_]);
              dv_nxt    = sum_r[CW_-1:0];
              cnt_nxt   = CNT_LAST;
              state_nxt = A_AVG;
            end
            default: begin
              done_nxt = 1'b1;
            end
          endcase
        end
      end

      // Window mean of the current sum, then W times the new value.
      A_MEAN: begin
        rem_nxt = div_rem;
        dv_nxt  = div_quot;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          mean_nxt  = div_quot;
          ma_nxt    = PW'(v);
          mb_nxt    = W_SW;
          macc_nxt  = '0;
          state_nxt = A_WV;
        end
      end

      // Distance of W*v from the sum, then the square of the sum.
      A_WV: begin
        if (mul_fin) begin
          d_nxt     = (wv >= sum_r) ? (wv - sum_r) : (sum_r - wv);
          ma_nxt    = PW'(sum_r);
          mb_nxt    = sum_r;
          macc_nxt  = '0;
          state_nxt = A_SS;
        end
      end

      // Square of the sum is kept, then W times the sum of squares.
      A_SS: begin
        if (mul_fin) begin
          ss_nxt    = wq;
          ma_nxt    = PW'(sumsq_r);
          mb_nxt    = W_SW;
          macc_nxt  = '0;
          state_nxt = A_WQ;
        end
      end

      // Scaled variance, clamped at zero, then the squared distance.
      A_WQ: begin
        if (mul_fin) begin
          var_nxt   = (wq >= ss_r) ? (wq - ss_r) : '0;
          ma_nxt    = PW'(d_r);
          mb_nxt    = d_r;
          macc_nxt  = '0;
          state_nxt = A_DD;
        end
      end

      // Squared distance is kept, then k squared times the variance.
      A_DD: begin
        if (mul_fin) begin
          dd_nxt    = wq;
          ma_nxt    = PW'(var_r);
          mb_nxt    = SW'(ksq);
          macc_nxt  = '0;
          state_nxt = A_KV;
        end
      end

      // The value lies outside the band when its distance exceeds the bound.
      A_KV: begin
        if (mul_fin) begin
          outside_nxt = (PW'(dd_r) > macc_r);
          done_nxt    = 1'b1;
          state_nxt   = A_IDLE;
        end
      end

      // Oldest entry reads as zero until the ring has wrapped once.
      A_RD: begin
        o_nxt     = filled ? ram_rdata : '0;
        ma_nxt    = PW'(n_r);
        mb_nxt    = SW'(n_r);
        macc_nxt  = '0;
        state_nxt = A_NN;
      end

      // Square of the new value, then the square of the old one.
      A_NN: begin
        if (mul_fin) begin
          ss_nxt    = wq;
          ma_nxt    = PW'(o_r);
          mb_nxt    = SW'(o_r);
          macc_nxt  = '0;
          state_nxt = A_OO;
        end
      end

      // Replace the old entry and update both running sums.
      A_OO: begin
        if (mul_fin) begin
          sum_nxt   = sum_r + SW'(n_r) - SW'(o_r);
          sumsq_nxt = sumsq_r + QW'(ss_r) - QW'(macc_r);
          ram_we    = 1'b1;
          done_nxt  = 1'b1;
          state_nxt = A_IDLE;
        end
      end

      // Window average of the updated sum.
      A_AVG: begin
        rem_nxt = div_rem;
        dv_nxt  = div_quot;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          avg_nxt   = div_quot;
          done_nxt  = 1'b1;
          state_nxt = A_IDLE;
        end
      end

      default: begin
        state_nxt = A_IDLE;
      end
    endcase
  end

  // State, running sums and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
      sum_r   <= '0;
      sumsq_r <= '0;
      mb_r    <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      sum_r   <= sum_nxt;
      sumsq_r <= sumsq_nxt;
      mb_r    <= mb_nxt;
    end
    mean_r    <= mean_nxt;
    avg_r     <= avg_nxt;
    d_r       <= d_nxt;
    ss_r      <= ss_nxt;
    var_r     <= var_nxt;
    dd_r      <= dd_nxt;
    n_r       <= n_nxt;
    o_r       <= o_nxt;
    outside_r <= outside_nxt;
    ma_r      <= ma_nxt;
    macc_r    <= macc_nxt;
    dv_r      <= dv_nxt;
    rem_r     <= rem_nxt;
    cnt_r     <= cnt_nxt;
  end

  assign sts.done    = done_r;
  assign sts.outside = outside_r;
  assign avg         = avg_r;

  // A command arrives only while the lane is idle.
  `GMA_ASSERT(a_start_idle, clk, rst_n, cmd.start, state_r == A_IDLE, "command while lane busy")
  // Completion is a single-cycle pulse.
  `GMA_ASSERT_NEXT(a_done_pulse, clk, rst_n, done_r, !done_r, "done held for two cycles")
  // The partial remainder stays below the window depth while dividing.
  `GMA_ASSERT(a_rem_bound, clk, rst_n, state_r == A_MEAN || state_r == A_AVG, rem_r < W_RW, "divider remainder out of range")

endmodule

`default_nettype wire

// File: hdl/gaze_moving_average_outlier.sv
// Top level of the gaze moving-average filter with sigma outlier gate.
//
//   channel  dir  handshake          payload
//   in_gaze  in   valid/ready        gaze_x, gaze_y  (Q12.4, zero = invalid)
//   out_avg  out  valid/ready        avg_x, avg_y    (window averages, Q12.4)
//   cfg      in   cfg_we, no wait    cfg_index, cfg_wdata
//
// An item runs longest with the sigma gate on and shortest when nothing is stored; the
// bit-serial multiplier and divider of each axis lane, one operand bit per cycle, set its
// run time. A multiply ends early on short operands, so the lanes may finish apart and the
// slower one counts.
// Reset is synchronous and needs no clearing pass: a fill flag makes unwritten
// ring entries read as zero. in_gaze is ready whenever the sequencer is idle;
// a result waits in the output register while out_avg stalls.
`default_nettype none
`include "gaze_moving_average_outlier_macros.svh"

module gaze_moving_average_outlier #(
  parameter int WINDOW = gma_pkg::WINDOW_DEF,
  localparam int AW = $clog2(WINDOW)
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  gma_gaze_if.sink                              in_gaze,
  gma_avg_if.source                             out_avg,
  input  wire logic                             cfg_we,
  input  wire logic [gma_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [gma_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam logic [AW-1:0] SLOT_LAST = AW'(WINDOW - 1);

  typedef enum logic [2:0] {
    T_IDLE,
    T_TEST,
    T_PUSH,
    T_AVG,
    T_HOLD
  } top_state_t;

  top_state_t state_r, state_nxt;
  gma_pkg::gma_cmd_t cmd_r, cmd_nxt;
  logic [AW-1:0]                  slot_r, slot_nxt;
  logic                           filled_r, filled_nxt;
  logic [gma_pkg::COORD_W-1:0]    gx_r, gx_nxt;
  logic [gma_pkg::COORD_W-1:0]    gy_r, gy_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [gma_pkg::COORD_W-1:0]    avg_x_r, avg_x_nxt;
  logic [gma_pkg::COORD_W-1:0]    avg_y_r, avg_y_nxt;
  logic                           lane_x_done_r, lane_x_done_nxt;
  logic                           lane_y_done_r, lane_y_done_nxt;
  logic                           outlier_enable_r;
  logic [gma_pkg::GAUSS_W-1:0]    gauss_factor_r;

  logic                           in_accept;
  logic                           pt_valid;
  logic                           lanes_done;
  logic                           seq_waiting;
  gma_pkg::gma_sts_t              sts_x;
  gma_pkg::gma_sts_t              sts_y;
  logic [gma_pkg::COORD_W-1:0]    lane_avg_x;
  logic [gma_pkg::COORD_W-1:0]    lane_avg_y;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outlier_enable_r <= 1'b0;
      gauss_factor_r   <= gma_pkg::GAUSS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gma_pkg::CFG_OUTLIER_ENABLE: outlier_enable_r <= cfg_wdata[0];
        gma_pkg::CFG_GAUSS_FACTOR:   gauss_factor_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Axis lanes take the same commands; their run times depend on the data.
  gma_axis #(
    .WINDOW (WINDOW)
  ) u_axis_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd_r),
    .slot   (slot_r),
    .filled (filled_r),
    .gauss  (gauss_factor_r),
    .v      (gx_r),
    .sts    (sts_x),
    .avg    (lane_avg_x)
  );

  gma_axis #(
    .WINDOW (WINDOW)
  ) u_axis_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd_r),
    .slot   (slot_r),
    .filled (filled_r),
    .gauss  (gauss_factor_r),
    .v      (gy_r),
    .sts    (sts_y),
    .avg    (lane_avg_y)
  );

  assign in_gaze.ready = (state_r == T_IDLE);
  assign in_accept     = in_gaze.valid && in_gaze.ready;
  assign pt_valid      = (in_gaze.gaze_x != '0) && (in_gaze.gaze_y != '0);

  // A command is complete once both lanes have reported, in any order.
  assign lanes_done  = (lane_x_done_r || sts_x.done) && (lane_y_done_r || sts_y.done);
  assign seq_waiting = (state_r == T_TEST) || (state_r == T_PUSH) || (state_r == T_AVG);

  // Item sequencer: optional gate test, store of valid points, average, then hand over the result.
  always_comb begin
    state_nxt       = state_r;
    cmd_nxt         = '{start: 1'b0, op: gma_pkg::OP_AVG, keep: 1'b0};
    slot_nxt        = slot_r;
    filled_nxt      = filled_r;
    gx_nxt          = gx_r;
    gy_nxt          = gy_r;
    out_valid_nxt   = out_valid_r && !out_avg.ready;
    avg_x_nxt       = avg_x_r;
    avg_y_nxt       = avg_y_r;
    lane_x_done_nxt = lane_x_done_r || sts_x.done;
    lane_y_done_nxt = lane_y_done_r || sts_y.done;

    unique case (state_r)
      T_IDLE: begin
        if (in_accept) begin
          gx_nxt = in_gaze.gaze_x;
          gy_nxt = in_gaze.gaze_y;
          if (pt_valid && outlier_enable_r) begin
            cmd_nxt   = '{start: 1'b1, op: gma_pkg::OP_TEST, keep: 1'b0};
            state_nxt = T_TEST;
          end else if (pt_valid) begin
            cmd_nxt   = '{start: 1'b1, op: gma_pkg::OP_PUSH, keep: 1'b1};
            state_nxt = T_PUSH;
          end else begin
            cmd_nxt   = '{start: 1'b1, op: gma_pkg::OP_AVG, keep: 1'b0};
            state_nxt = T_AVG;
          end
        end
      end

      // The point is kept if either axis lies outside its band.
      T_TEST: begin
        if (lanes_done) begin
          lane_x_done_nxt = 1'b0;
          lane_y_done_nxt = 1'b0;
          cmd_nxt   = '{start: 1'b1, op: gma_pkg::OP_PUSH,
                        keep: sts_x.outside || sts_y.outside};
          state_nxt = T_PUSH;
        end
      end

      // Advance the ring slot; the ring is full once it wraps.
      T_PUSH: begin
        if (lanes_done) begin
          lane_x_done_nxt = 1'b0;
          lane_y_done_nxt = 1'b0;
          if (slot_r == SLOT_LAST) begin
            slot_nxt   = '0;
            filled_nxt = 1'b1;
          end else begin
            slot_nxt = slot_r + 1'b1;
          end
          cmd_nxt   = '{start: 1'b1, op: gma_pkg::OP_AVG, keep: 1'b0};
          state_nxt = T_AVG;
        end
      end

      T_AVG: begin
        if (lanes_done) begin
          lane_x_done_nxt = 1'b0;
          lane_y_done_nxt = 1'b0;
          state_nxt       = T_HOLD;
        end
      end

      // Load the output register once it is free.
      T_HOLD: begin
        if (!out_valid_r || out_avg.ready) begin
          out_valid_nxt = 1'b1;
          avg_x_nxt     = lane_avg_x;
          avg_y_nxt     = lane_avg_y;
          state_nxt     = T_IDLE;
        end
      end

      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

  // Sequencer state and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= T_IDLE;
      cmd_r         <= '{start: 1'b0, op: gma_pkg::OP_AVG, keep: 1'b0};
      slot_r        <= '0;
      filled_r      <= 1'b0;
      out_valid_r   <= 1'b0;
      lane_x_done_r <= 1'b0;
      lane_y_done_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cmd_r         <= cmd_nxt;
      slot_r        <= slot_nxt;
      filled_r      <= filled_nxt;
      out_valid_r   <= out_valid_nxt;
      lane_x_done_r <= lane_x_done_nxt;
      lane_y_done_r <= lane_y_done_nxt;
    end
    gx_r    <= gx_nxt;
    gy_r    <= gy_nxt;
    avg_x_r <= avg_x_nxt;
    avg_y_r <= avg_y_nxt;
  end

  assign out_avg.valid = out_valid_r;
  assign out_avg.avg_x = avg_x_r;
  assign out_avg.avg_y = avg_y_r;

  // Each lane reports completion once per command.
  `GMA_ASSERT(a_x_done_once, clk, rst_n, sts_x.done, !lane_x_done_r, "x lane done twice")
  `GMA_ASSERT(a_y_done_once, clk, rst_n, sts_y.done, !lane_y_done_r, "y lane done twice")
  // A lane completes only while the sequencer waits for it.
  `GMA_ASSERT(a_done_when_waiting, clk, rst_n, sts_x.done || sts_y.done, seq_waiting, "lane done while idle")
  // Once the ring has wrapped it stays full.
  `GMA_ASSERT_NEXT(a_filled_sticky, clk, rst_n, filled_r, filled_r, "fill flag dropped")
  // The write slot stays inside the ring.
  `GMA_ASSERT(a_slot_bound, clk, rst_n, 1'b1, slot_r <= SLOT_LAST, "write slot beyond ring")

endmodule

`default_nettype wire
